// ===== design/crossing_type_rate_accumulator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Crossing-type rate accumulator assertion macros
// Concurrent assertion wrappers, left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef CROSSING_TYPE_RATE_ACCUMULATOR_CORE_MACROS_SVH
`define CROSSING_TYPE_RATE_ACCUMULATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Checked property with an active-low reset that disables it.
`define CRTA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds during reset.
`define CRTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRTA_ASSERT(lbl, clk, rstn, prop, msg)
`define CRTA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/crta_pkg.sv =====
// ----------------------------------------------------------------------------
// Crossing-type rate accumulator package
// Widths, constants, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package crta_pkg;

    localparam int MASK_W     = 4;
    localparam int THR_W      = 16;
    localparam int VAL_W      = 17;
    localparam int TYPE_W     = 2;
    localparam int TIME_W     = 64;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 48;
    localparam int MEAN_W     = 34;
    localparam int FRAC_W     = 19;
    localparam int RF_W       = 17;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_FIELDS = 3;
    localparam int DIVD_W     = 64;
    localparam int DIVS_W     = 32;
    localparam int Q_FRAC     = 16;
    localparam int MACC_W     = 38;
    localparam int FACC_W     = 21;
    localparam int MICRO_W    = 20;
    localparam int PROD_W     = 36;
    localparam int STEP_W     = 7;

    localparam logic [MICRO_W-1:0]       MICRO      = 20'd1000000;
    localparam logic [DIVD_W-1:0]        MEAN_CAP   = 64'h0000_0002_0000_0000;
    localparam logic [DIVD_W-1:0]        FRAC_ONE   = 64'd65536;
    localparam logic [RF_W-1:0]          FRAC_CAP   = 17'd65536;
    localparam logic signed [MACC_W-1:0] MEAN_MIN   = 38'sh3E_0000_0000;
    localparam logic signed [MACC_W-1:0] MEAN_MAX   = 38'sh01_FFFF_FFFF;
    localparam logic signed [FACC_W-1:0] FRAC_MIN   = 21'sh1E0000;
    localparam logic signed [FACC_W-1:0] FRAC_MAX   = 21'sh020000;
    localparam logic [STEP_W-1:0]        STEPS_FULL = 7'd64;
    localparam logic [STEP_W-1:0]        STEPS_MOD  = 7'd32;

    localparam logic [THR_W-1:0]  THR_RESET      = 16'd5;
    localparam logic [THR_W-1:0]  INTERVAL_RESET = 16'd100;
    localparam logic [MASK_W-1:0] ADD_RESET      = 4'd9;
    localparam logic [MASK_W-1:0] SUB_RESET      = 4'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THR_A,
        REG_THR_B,
        REG_THR_C,
        REG_INTERVAL,
        REG_FORCE,
        REG_ADD_MASK,
        REG_SUB_MASK
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHECK,
        ST_MOD_WAIT,
        ST_TIME_UPD,
        ST_AN_INIT,
        ST_CELL,
        ST_DIV_M,
        ST_WAIT_M,
        ST_DIV_F,
        ST_WAIT_F,
        ST_EMIT,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic acc_step;
        logic mod_start;
        logic time_mult;
        logic time_upd;
        logic an_init;
        logic cell_load;
        logic div_mean_start;
        logic div_frac_start;
        logic mean_take;
        logic frac_take;
        logic next_type;
        logic emit;
        logic next_cnt;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic type_last;
        logic div_busy;
        logic run_event;
        logic run_time;
        logic force_mode;
        logic dn_zero;
        logic out_full;
        logic out_fire;
    } sts_t;

endpackage
`default_nettype wire

// ===== design/crta_div.sv =====
// ----------------------------------------------------------------------------
// Crossing-type rate accumulator divider
// Restoring divider, one quotient bit per cycle, for a chosen step count.
// ----------------------------------------------------------------------------
`default_nettype none
module crta_div
    import crta_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    input  wire logic [STEP_W-1:0] steps,
    output logic                   busy,
    output logic [DIVD_W-1:0]      quotient,
    output logic [DIVS_W-1:0]      remainder
);

    logic [DIVD_W-1:0] q_reg;
    logic [DIVS_W-1:0] r_reg;
    logic [DIVS_W-1:0] d_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    assign trial = {r_reg, q_reg[DIVD_W-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            q_reg <= {q_reg[DIVD_W-2:0], ge};
        end
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule
`default_nettype wire

// ===== design/crta_dp.sv =====
// ----------------------------------------------------------------------------
// Crossing-type rate accumulator datapath
// Configuration, per-cell delta counters, trigger logic, rate combination
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module crta_dp
    import crta_pkg::*;
#(
    parameter int NUM_COUNTERS       = 3,
    parameter int NUM_CROSSING_TYPES = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [TYPE_W-1:0]     crossing_type,
    input  wire logic signed [VAL_W-1:0] value_a,
    input  wire logic signed [VAL_W-1:0] value_b,
    input  wire logic signed [VAL_W-1:0] value_c,
    input  wire logic [TIME_W-1:0]     time_us,
    input  wire logic                  out_ready,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    output logic                       out_valid,
    output logic [IDX_W-1:0]           counter_index,
    output logic signed [MEAN_W-1:0]   mean_rate,
    output logic signed [FRAC_W-1:0]   over_fraction,
    output logic                       last
);

    localparam int REP    = (NUM_COUNTERS < MAX_FIELDS) ? NUM_COUNTERS : MAX_FIELDS;
    localparam int CELLS  = REP * NUM_CROSSING_TYPES;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CI_W   = (REP > 1) ? $clog2(REP) : 1;
    localparam int TB_W   = (NUM_CROSSING_TYPES > 1) ? $clog2(NUM_CROSSING_TYPES) : 1;

    // Configuration registers.
    logic [THR_W-1:0]  thr_a_reg;
    logic [THR_W-1:0]  thr_b_reg;
    logic [THR_W-1:0]  thr_c_reg;
    logic [THR_W-1:0]  interval_reg;
    logic              force_reg;
    logic [MASK_W-1:0] add_mask_reg;
    logic [MASK_W-1:0] sub_mask_reg;

    // Captured item.
    logic [TYPE_W-1:0] type_reg;
    logic [VAL_W-1:0]  val_reg [MAX_FIELDS];
    logic [TIME_W-1:0] now_reg;

    // Trigger state.
    logic [CNT_W-1:0]  ev_cnt_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TIME_W-1:0] elapsed_reg;

    // Cells hold the change since the previous analysis.
    logic [CNT_W-1:0]  cnt_mem_reg [CELLS];
    logic [SUM_W-1:0]  sum_mem_reg [CELLS];
    logic [CNT_W-1:0]  ov_mem_reg  [CELLS];

    logic [CI_W-1:0]   ci_reg;
    logic [TB_W-1:0]   tb_reg;
    logic [CNT_W-1:0]  dn_reg;
    logic [SUM_W-1:0]  ds_reg;
    logic [CNT_W-1:0]  dov_reg;
    logic signed [MACC_W-1:0] mean_acc_reg;
    logic signed [FACC_W-1:0] frac_acc_reg;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic signed [MEAN_W-1:0] out_mean_reg;
    logic signed [FRAC_W-1:0] out_frac_reg;
    logic                     out_last_reg;

    logic [CELL_W-1:0] addr;
    logic [VAL_W-1:0]  cur_val;
    logic [THR_W-1:0]  cur_thr;
    logic              type_known;
    logic              present;
    logic              over;
    logic              mb_add;
    logic              mb_sub;
    logic [THR_W-1:0]  n_div;
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic [STEP_W-1:0] div_steps;
    logic              div_busy;
    logic [DIVD_W-1:0] div_q;
    logic [DIVS_W-1:0] div_r;
    logic [MEAN_W-1:0] rm;
    logic [RF_W-1:0]   rf;
    logic signed [MACC_W-1:0] rm_ext;
    logic signed [FACC_W-1:0] rf_ext;
    logic signed [MACC_W-1:0] mean_sat;
    logic signed [FACC_W-1:0] frac_sat;

    assign type_known = 32'(type_reg) < NUM_CROSSING_TYPES;
    assign addr = CELL_W'(((cmd.acc_step ? 32'(type_reg) : 32'(tb_reg)) * REP)
                          + 32'(ci_reg));
    assign cur_val = val_reg[ci_reg];
    assign present = !cur_val[VAL_W-1];
    assign over    = cur_val[THR_W-1:0] > cur_thr;

    always_comb
    begin
        case (32'(ci_reg))
            0:       cur_thr = thr_a_reg;
            1:       cur_thr = thr_b_reg;
            default: cur_thr = thr_c_reg;
        endcase
    end

    assign mb_add = (32'(tb_reg) < MASK_W) ? add_mask_reg[2'(tb_reg)] : 1'b0;
    assign mb_sub = (32'(tb_reg) < MASK_W) ? sub_mask_reg[2'(tb_reg)] : 1'b0;

    // A zero interval behaves as one in event mode.
    assign n_div = (interval_reg == '0) ? THR_W'(1) : interval_reg;

    assign div_start = cmd.mod_start | cmd.div_mean_start | cmd.div_frac_start;

    always_comb
    begin
        if (cmd.mod_start)
        begin
            // Preloading the count in the upper half gives its remainder in 32 steps.
            div_dividend = {ev_cnt_reg, {(DIVD_W-CNT_W){1'b0}}};
            div_divisor  = DIVS_W'(n_div);
            div_steps    = STEPS_MOD;
        end
        else if (cmd.div_mean_start)
        begin
            div_dividend = {ds_reg, {Q_FRAC{1'b0}}};
            div_divisor  = dn_reg;
            div_steps    = STEPS_FULL;
        end
        else
        begin
            div_dividend = {{(DIVD_W-CNT_W-Q_FRAC){1'b0}}, dov_reg, {Q_FRAC{1'b0}}};
            div_divisor  = dn_reg;
            div_steps    = STEPS_FULL;
        end
    end

    crta_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign rm = (div_q > MEAN_CAP) ? MEAN_CAP[MEAN_W-1:0] : div_q[MEAN_W-1:0];
    assign rf = (div_q > FRAC_ONE) ? FRAC_CAP : div_q[RF_W-1:0];
    assign rm_ext = signed'({{(MACC_W-MEAN_W){1'b0}}, rm});
    assign rf_ext = signed'({{(FACC_W-RF_W){1'b0}}, rf});

    always_comb
    begin
        if (mean_acc_reg < MEAN_MIN)
        begin
            mean_sat = MEAN_MIN;
        end
        else if (mean_acc_reg > MEAN_MAX)
        begin
            mean_sat = MEAN_MAX;
        end
        else
        begin
            mean_sat = mean_acc_reg;
        end
        if (frac_acc_reg < FRAC_MIN)
        begin
            frac_sat = FRAC_MIN;
        end
        else if (frac_acc_reg > FRAC_MAX)
        begin
            frac_sat = FRAC_MAX;
        end
        else
        begin
            frac_sat = frac_acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_a_reg    <= THR_RESET;
            thr_b_reg    <= THR_RESET;
            thr_c_reg    <= THR_RESET;
            interval_reg <= INTERVAL_RESET;
            force_reg    <= 1'b0;
            add_mask_reg <= ADD_RESET;
            sub_mask_reg <= SUB_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_THR_A:    thr_a_reg    <= cfg_data;
                REG_THR_B:    thr_b_reg    <= cfg_data;
                REG_THR_C:    thr_c_reg    <= cfg_data;
                REG_INTERVAL: interval_reg <= cfg_data;
                REG_FORCE:    force_reg    <= cfg_data[0];
                REG_ADD_MASK: add_mask_reg <= cfg_data[MASK_W-1:0];
                REG_SUB_MASK: sub_mask_reg <= cfg_data[MASK_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            type_reg   <= crossing_type;
            val_reg[0] <= value_a;
            val_reg[1] <= value_b;
            val_reg[2] <= value_c;
            now_reg    <= time_us;
        end
        if (cmd.time_mult)
        begin
            prod_reg    <= PROD_W'(interval_reg) * PROD_W'(MICRO);
            elapsed_reg <= now_reg - last_time_reg;
        end
        if (cmd.cell_load)
        begin
            dn_reg  <= cnt_mem_reg[addr];
            ds_reg  <= sum_mem_reg[addr];
            dov_reg <= ov_mem_reg[addr];
        end
        if (cmd.emit)
        begin
            out_idx_reg  <= IDX_W'(ci_reg);
            out_mean_reg <= mean_sat[MEAN_W-1:0];
            out_frac_reg <= frac_sat[FRAC_W-1:0];
            out_last_reg <= sts.cnt_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_cnt_reg    <= '0;
            last_time_reg <= '0;
            ci_reg        <= '0;
            tb_reg        <= '0;
            mean_acc_reg  <= '0;
            frac_acc_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < CELLS; k++)
            begin
                cnt_mem_reg[k] <= '0;
                sum_mem_reg[k] <= '0;
                ov_mem_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cmd.load_in)
            begin
                ev_cnt_reg <= ev_cnt_reg + 1'b1;
                ci_reg     <= '0;
            end
            if (cmd.acc_step)
            begin
                if (type_known && present)
                begin
                    cnt_mem_reg[addr] <= cnt_mem_reg[addr] + 1'b1;
                    sum_mem_reg[addr] <= sum_mem_reg[addr]
                                         + SUM_W'(cur_val[THR_W-1:0]);
                    ov_mem_reg[addr]  <= ov_mem_reg[addr] + CNT_W'(over);
                end
                ci_reg <= sts.cnt_last ? '0 : ci_reg + 1'b1;
            end
            if (cmd.time_upd && ((last_time_reg == '0) || sts.run_time))
            begin
                last_time_reg <= now_reg;
            end
            if (cmd.an_init)
            begin
                ci_reg       <= '0;
                tb_reg       <= '0;
                mean_acc_reg <= '0;
                frac_acc_reg <= '0;
            end
            if (cmd.cell_load)
            begin
                cnt_mem_reg[addr] <= '0;
                sum_mem_reg[addr] <= '0;
                ov_mem_reg[addr]  <= '0;
            end
            // Both mask bits set cancel out, so only one-sided bits act.
            if (cmd.mean_take)
            begin
                if (mb_add && !mb_sub)
                begin
                    mean_acc_reg <= mean_acc_reg + rm_ext;
                end
                else if (mb_sub && !mb_add)
                begin
                    mean_acc_reg <= mean_acc_reg - rm_ext;
                end
            end
            if (cmd.frac_take)
            begin
                if (mb_add && !mb_sub)
                begin
                    frac_acc_reg <= frac_acc_reg + rf_ext;
                end
                else if (mb_sub && !mb_add)
                begin
                    frac_acc_reg <= frac_acc_reg - rf_ext;
                end
            end
            if (cmd.next_type)
            begin
                tb_reg <= tb_reg + 1'b1;
            end
            if (cmd.next_cnt)
            begin
                ci_reg       <= ci_reg + 1'b1;
                tb_reg       <= '0;
                mean_acc_reg <= '0;
                frac_acc_reg <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.cnt_last   = 32'(ci_reg) == REP - 1;
    assign sts.type_last  = 32'(tb_reg) == NUM_CROSSING_TYPES - 1;
    assign sts.div_busy   = div_busy;
    assign sts.run_event  = div_r == '0;
    assign sts.run_time   = (last_time_reg != '0) && (elapsed_reg > TIME_W'(prod_reg));
    assign sts.force_mode = force_reg;
    assign sts.dn_zero    = dn_reg == '0;
    assign sts.out_full   = out_valid_reg;
    assign sts.out_fire   = out_valid_reg & out_ready;

    assign out_valid     = out_valid_reg;
    assign counter_index = out_idx_reg;
    assign mean_rate     = out_mean_reg;
    assign over_fraction = out_frac_reg;
    assign last          = out_last_reg;

endmodule
`default_nettype wire

// ===== design/crta_ctrl.sv =====
// ----------------------------------------------------------------------------
// Crossing-type rate accumulator controller
// Sequences accumulation, the analysis trigger and the per-cell analysis.
// ----------------------------------------------------------------------------
`default_nettype none
`include "crossing_type_rate_accumulator_core_macros.svh"
module crta_ctrl
    import crta_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire sts_t sts,
    output logic      in_ready,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (sts.cnt_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.force_mode ? ST_MOD_WAIT : ST_TIME_UPD;
            end
            ST_MOD_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = sts.run_event ? ST_AN_INIT : ST_IDLE;
                end
            end
            ST_TIME_UPD:
            begin
                state_next = sts.run_time ? ST_AN_INIT : ST_IDLE;
            end
            ST_AN_INIT:  state_next = ST_CELL;
            ST_CELL:     state_next = ST_DIV_M;
            ST_DIV_M:
            begin
                // A cell with no new entries contributes nothing.
                if (!sts.dn_zero)
                begin
                    state_next = ST_WAIT_M;
                end
                else
                begin
                    state_next = sts.type_last ? ST_EMIT : ST_CELL;
                end
            end
            ST_WAIT_M:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_DIV_F;
                end
            end
            ST_DIV_F:    state_next = ST_WAIT_F;
            ST_WAIT_F:
            begin
                if (!sts.div_busy)
                begin
                    state_next = sts.type_last ? ST_EMIT : ST_CELL;
                end
            end
            ST_EMIT:     state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (sts.out_fire)
                begin
                    state_next = sts.cnt_last ? ST_IDLE : ST_CELL;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_ACC:      cmd.acc_step = 1'b1;
            ST_CHECK:
            begin
                cmd.mod_start = sts.force_mode;
                cmd.time_mult = !sts.force_mode;
            end
            ST_TIME_UPD: cmd.time_upd = 1'b1;
            ST_AN_INIT:  cmd.an_init = 1'b1;
            ST_CELL:     cmd.cell_load = 1'b1;
            ST_DIV_M:
            begin
                cmd.div_mean_start = !sts.dn_zero;
                cmd.next_type      = sts.dn_zero && !sts.type_last;
            end
            ST_WAIT_M:   cmd.mean_take = !sts.div_busy;
            ST_DIV_F:    cmd.div_frac_start = 1'b1;
            ST_WAIT_F:
            begin
                cmd.frac_take = !sts.div_busy;
                cmd.next_type = !sts.div_busy && !sts.type_last;
            end
            ST_EMIT:     cmd.emit = 1'b1;
            ST_OUT_WAIT: cmd.next_cnt = sts.out_fire && !sts.cnt_last;
            default:     ;
        endcase
    end

    `CRTA_ASSERT(a_div_start_idle, clk, rst_n, (cmd.mod_start || cmd.div_mean_start || cmd.div_frac_start) |-> !sts.div_busy, "divider started while busy")
    `CRTA_ASSERT(a_emit_empty, clk, rst_n, cmd.emit |-> !sts.out_full, "result written over a waiting result")
    `CRTA_ASSERT(a_accept_drained, clk, rst_n, (in_valid && in_ready) |-> !sts.out_full, "item accepted while a result waits")
    `CRTA_ASSERT(a_done_idle, clk, rst_n, (state_reg == ST_OUT_WAIT && sts.out_fire && sts.cnt_last) |=> (state_reg == ST_IDLE), "analysis did not end after last result")

endmodule
`default_nettype wire

// ===== design/crossing_type_rate_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// Crossing-type rate accumulator core
// Per crossing type counter statistics with periodic masked rate analysis.
// ----------------------------------------------------------------------------
// Items enter on the in channel (valid/ready) and are handled one at a time.
// Each item updates one cell per counter, one counter a cycle, then the
// analysis check runs; in event mode it waits for the 32-step remainder
// of the shared divider. When an analysis fires, each cell of a counter
// with new entries takes two 64-step divisions; one result per counter
// leaves on the out channel, last marking the final one. The divider is
// the throughput limit. If the receiver stalls, the result stays in the
// output register and the analysis waits; no new item is taken until
// the whole analysis is out. Configuration writes (cfg channel, always
// ready) are meant for idle time. Reset clears all counters and the time
// stamp and loads the register defaults; the block is ready as soon as
// reset is released.
// ----------------------------------------------------------------------------
`default_nettype none
module crossing_type_rate_accumulator_core
    import crta_pkg::*;
#(
    parameter int NUM_COUNTERS       = 3,
    parameter int NUM_CROSSING_TYPES = 4
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [TYPE_W-1:0]       crossing_type,
    input  wire logic signed [VAL_W-1:0] value_a,
    input  wire logic signed [VAL_W-1:0] value_b,
    input  wire logic signed [VAL_W-1:0] value_c,
    input  wire logic [TIME_W-1:0]       time_us,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [IDX_W-1:0]             counter_index,
    output logic signed [MEAN_W-1:0]     mean_rate,
    output logic signed [FRAC_W-1:0]     over_fraction,
    output logic                         last
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    crta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    crta_dp #(
        .NUM_COUNTERS       (NUM_COUNTERS),
        .NUM_CROSSING_TYPES (NUM_CROSSING_TYPES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .crossing_type (crossing_type),
        .value_a       (value_a),
        .value_b       (value_b),
        .value_c       (value_c),
        .time_us       (time_us),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .counter_index (counter_index),
        .mean_rate     (mean_rate),
        .over_fraction (over_fraction),
        .last          (last)
    );

endmodule
`default_nettype wire

// ===== test/tb_crossing_type_rate_accumulator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Crossing-type rate accumulator testbench
// Drives events with bursty valid and a stalling receiver, predicts every
// analysis result with an internal model of the counters and snapshots, and
// compares each result field by field. Registers are rewritten between
// phases, covering time mode, event mode and the mask and threshold extremes.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_crossing_type_rate_accumulator_core;
    import crta_pkg::*;

    localparam int  NCNT      = 3;
    localparam int  NTYPE     = 4;
    localparam int  NCELL     = NCNT * NTYPE;
    localparam int  IDLE_GAP  = 100;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [MEAN_W-1:0] mean;
        logic signed [FRAC_W-1:0] frac;
        logic                     last;
    } rate_result_t;

    class rate_scoreboard;
        int unsigned     thr[NCNT];
        int unsigned     interval;
        bit              event_mode;
        bit [3:0]        add_mask;
        bit [3:0]        sub_mask;
        int unsigned     entries[NCELL];
        longint unsigned sums[NCELL];
        int unsigned     overs[NCELL];
        int unsigned     snap_entries[NCELL];
        longint unsigned snap_sums[NCELL];
        int unsigned     snap_overs[NCELL];
        int unsigned     event_count;
        longint unsigned last_time;
        rate_result_t    pending[$];
        int              errors;

        function new();
            thr = '{5, 5, 5};
            interval   = 100;
            event_mode = 0;
            add_mask   = 4'd9;
            sub_mask   = 4'd6;
            foreach (entries[k])
            begin
                entries[k] = 0; sums[k] = 0; overs[k] = 0;
                snap_entries[k] = 0; snap_sums[k] = 0; snap_overs[k] = 0;
            end
            event_count = 0;
            last_time   = 0;
            errors      = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_THR_A:    thr[0] = data;
                REG_THR_B:    thr[1] = data;
                REG_THR_C:    thr[2] = data;
                REG_INTERVAL: interval = data;
                REG_FORCE:    event_mode = data[0];
                REG_ADD_MASK: add_mask = data[3:0];
                REG_SUB_MASK: sub_mask = data[3:0];
                default: ;
            endcase
        endfunction

        function void run_analysis();
            longint          mean;
            longint          frac;
            int              c;
            int unsigned     dn;
            int unsigned     dov;
            longint unsigned ds;
            longint unsigned qm;
            longint unsigned qf;
            longint          rm;
            longint          rf;
            rate_result_t    r;
            for (int i = 0; i < NCNT; i++)
            begin
                mean = 0;
                frac = 0;
                for (int b = 0; b < NTYPE; b++)
                begin
                    c   = b * NCNT + i;
                    dn  = entries[c] - snap_entries[c];
                    ds  = (sums[c] - snap_sums[c]) & 64'hFFFF_FFFF_FFFF;
                    dov = overs[c] - snap_overs[c];
                    rm  = 0;
                    rf  = 0;
                    if (dn != 0)
                    begin
                        qm = (ds << 16) / longint'(dn);
                        qf = (longint'(dov) << 16) / longint'(dn);
                        rm = (qm > 64'h2_0000_0000) ? 64'h2_0000_0000 : qm;
                        rf = (qf > 65536) ? 65536 : qf;
                    end
                    if (add_mask[b])
                    begin
                        mean += rm;
                        frac += rf;
                    end
                    if (sub_mask[b])
                    begin
                        mean -= rm;
                        frac -= rf;
                    end
                    snap_entries[c] = entries[c];
                    snap_sums[c]    = sums[c];
                    snap_overs[c]   = overs[c];
                end
                if (mean < -(64'sd1 << 33)) mean = -(64'sd1 << 33);
                if (mean > (64'sd1 << 33) - 1) mean = (64'sd1 << 33) - 1;
                if (frac < -131072) frac = -131072;
                if (frac > 131072) frac = 131072;
                r.idx  = i;
                r.mean = mean[MEAN_W-1:0];
                r.frac = frac[FRAC_W-1:0];
                r.last = (i == NCNT - 1);
                pending = {pending, r};
            end
        endfunction

        function void note_event(logic [TYPE_W-1:0] ctype, logic [VAL_W-1:0] va,
                                 logic [VAL_W-1:0] vb, logic [VAL_W-1:0] vc,
                                 logic [TIME_W-1:0] now);
            logic [VAL_W-1:0] vals[NCNT];
            int               c;
            bit               fire;
            longint unsigned  elapsed;
            vals = '{va, vb, vc};
            event_count++;
            for (int i = 0; i < NCNT; i++)
            begin
                // A set sign bit marks the counter as absent.
                if (!vals[i][VAL_W-1])
                begin
                    c = ctype * NCNT + i;
                    entries[c]++;
                    sums[c] = (sums[c] + vals[i][15:0]) & 64'hFFFF_FFFF_FFFF;
                    if (vals[i][15:0] > thr[i]) overs[c]++;
                end
            end
            fire = 0;
            if (event_mode)
                fire = (event_count % ((interval == 0) ? 1 : interval)) == 0;
            else if (last_time == 0)
                last_time = now;
            else
            begin
                elapsed = now - last_time;
                if (elapsed > longint'(interval) * 64'd1000000)
                begin
                    last_time = now;
                    fire = 1;
                end
            end
            if (fire) run_analysis();
        endfunction

        function void check_result(rate_result_t got);
            rate_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result: counter_index %0d", got.idx);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.idx !== exp_r.idx)
            begin
                $error("counter_index: expected %0d, got %0d", exp_r.idx, got.idx);
                errors++;
            end
            if (got.mean !== exp_r.mean)
            begin
                $error("mean_rate: expected %0d, got %0d", exp_r.mean, got.mean);
                errors++;
            end
            if (got.frac !== exp_r.frac)
            begin
                $error("over_fraction: expected %0d, got %0d", exp_r.frac, got.frac);
                errors++;
            end
            if (got.last !== exp_r.last)
            begin
                $error("last: expected %0d, got %0d", exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [TYPE_W-1:0]       crossing_type;
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
    logic signed [VAL_W-1:0] value_c;
    logic [TIME_W-1:0]       time_us;
    logic                    out_valid;
    logic                    out_ready;
    logic [IDX_W-1:0]        counter_index;
    logic signed [MEAN_W-1:0] mean_rate;
    logic signed [FRAC_W-1:0] over_fraction;
    logic                    last;

    rate_scoreboard  sb;
    longint          cycles;
    int              hold_off;
    int              burst_left;
    logic [TIME_W-1:0] clock_us;

    crossing_type_rate_accumulator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .crossing_type (crossing_type),
        .value_a       (value_a),
        .value_b       (value_b),
        .value_c       (value_c),
        .time_us       (time_us),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .counter_index (counter_index),
        .mean_rate     (mean_rate),
        .over_fraction (over_fraction),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Handshakes are observed here, before the block's own updates land.
    always @(posedge clk)
    begin
        rate_result_t r;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(reg_idx_t'(cfg_index), cfg_data);
            if (in_valid && in_ready)
                sb.note_event(crossing_type, value_a, value_b, value_c, time_us);
            if (out_valid && out_ready)
            begin
                r.idx  = counter_index;
                r.mean = mean_rate;
                r.frac = over_fraction;
                r.last = last;
                sb.check_result(r);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_crossing_type_rate_accumulator_core: errors");
            $finish;
        end
    end

    // Receiver: stalls on its own pattern, with a long hold-off on request.
    always @(negedge clk)
    begin
        int mode;
        mode = $urandom_range(0, 15);
        if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if ((cycles / 500) % 3 == 0)
            out_ready <= 1'b1;
        else
            out_ready <= (mode > 5);
    end

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    // Offers one item; the sender pauses between bursts of random length.
    task automatic send_event(logic [TYPE_W-1:0] ctype, logic [VAL_W-1:0] va,
                              logic [VAL_W-1:0] vb, logic [VAL_W-1:0] vc,
                              logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge clk);
        in_valid      <= 1'b1;
        crossing_type <= ctype;
        value_a       <= va;
        value_b       <= vb;
        value_c       <= vc;
        time_us       <= now;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return {1'b1, 16'($urandom)};
            2: return 17'h0FFFF;
            3: return 17'h00000;
            default: return {1'b0, 16'($urandom)};
        endcase
    endfunction

    // Advances the time stamp: mostly short steps, sometimes past the interval.
    function automatic logic [TIME_W-1:0] next_time();
        case ($urandom_range(0, 7))
            0, 1: clock_us = clock_us + longint'(sb.interval) * 64'd1000000
                             + $urandom_range(1, 2000000);
            2: clock_us = clock_us + longint'(sb.interval) * 64'd1000000;
            default: clock_us = clock_us + $urandom_range(0, 400000);
        endcase
        return clock_us;
    endfunction

    initial
    begin
        int kind;
        sb         = new();
        cycles     = 0;
        hold_off   = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        crossing_type = '0;
        value_a    = '0;
        value_b    = '0;
        value_c    = '0;
        time_us    = '0;
        out_ready  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Time mode with defaults: a zero stamp leaves no analysis time, then
        // the exact interval does not fire and one microsecond more does.
        send_event(2'd0, 17'h00000, 17'h0FFFF, '1, 64'd0);
        send_event(2'd1, 17'h00006, 17'h00005, 17'h10000, 64'd1000);
        send_event(2'd2, 17'h0FFFF, 17'h1FFFE, 17'h00007, 64'd2000);
        send_event(2'd3, 17'h00004, 17'h0FFFF, 17'h0FFFF, 64'd1000 + 64'd100000000);
        send_event(2'd3, '1, '1, '1, 64'd1001 + 64'd100000000);
        send_event(2'd0, 17'h00100, 17'h00000, 17'h00001, 64'd1002 + 64'd200000000);
        // Wrapping time difference across the top of the 64-bit range.
        send_event(2'd1, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 64'hFFFF_FFFF_FFFF_FF00);
        send_event(2'd2, 17'h00001, 17'h00002, 17'h00003, 64'd500000000);
        release_input();
        settle();

        // Event mode, interval zero acts as one; both masks cancel every type.
        write_reg(REG_THR_A, 16'd0);
        write_reg(REG_THR_B, 16'hFFFF);
        write_reg(REG_THR_C, 16'd0);
        write_reg(REG_INTERVAL, 16'd0);
        write_reg(REG_FORCE, 16'd1);
        write_reg(REG_ADD_MASK, 16'hF);
        write_reg(REG_SUB_MASK, 16'hF);
        send_event(2'd3, 17'h0FFFF, 17'h0FFFF, 17'h00000, 64'd7);
        release_input();
        settle();
        write_reg(REG_SUB_MASK, 16'd0);
        settle();
        for (int k = 0; k < 6; k++)
            send_event(2'(k % 4), 17'h0FFFF, 17'h0FFFF, 17'h00001, 64'd8 + k);
        release_input();
        settle();
        write_reg(REG_ADD_MASK, 16'd0);
        write_reg(REG_SUB_MASK, 16'hF);
        write_reg(REG_INTERVAL, 16'd3);
        for (int k = 0; k < 6; k++)
            send_event(2'(k % 4), 17'h0FFFF, '1, 17'h00000, 64'd20 + k);
        release_input();
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            kind = $urandom_range(0, 3);
            write_reg(REG_THR_A, (kind == 0) ? 16'hFFFF : 16'($urandom));
            write_reg(REG_THR_B, (kind == 1) ? 16'd0 : 16'($urandom_range(0, 70000)));
            write_reg(REG_THR_C, 16'($urandom));
            write_reg(REG_ADD_MASK, 16'($urandom_range(0, 15)));
            write_reg(REG_SUB_MASK, 16'($urandom_range(0, 15)));
            if (phase % 2 == 0)
            begin
                write_reg(REG_FORCE, 16'd1);
                write_reg(REG_INTERVAL, (phase == 6) ? 16'hFFFF
                                                     : 16'($urandom_range(0, 6)));
            end
            else
            begin
                write_reg(REG_FORCE, 16'd0);
                write_reg(REG_INTERVAL, (phase == 7) ? 16'hFFFF
                                                     : 16'($urandom_range(0, 3)));
                clock_us = {32'($urandom), 32'($urandom)};
            end
            if (phase == 2) hold_off = 4000;
            for (int k = 0; k < 26; k++)
                send_event(2'($urandom_range(0, 3)), pick_value(), pick_value(),
                           pick_value(), next_time());
            release_input();
            settle();
        end

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_crossing_type_rate_accumulator_core: clean");
        else
            $display("tb_crossing_type_rate_accumulator_core: errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/crta_pkg.sv
design/crta_div.sv
design/crta_dp.sv
design/crta_ctrl.sv
design/crossing_type_rate_accumulator_core.sv
test/tb_crossing_type_rate_accumulator_core.sv
